FILE: sv/kms_pkg.sv
// shared types, codes and helper functions for the key matrix scanner
`timescale 1ns / 1ps

package kms_pkg;

  localparam logic       OP_CLEAR  = 1'b0;
  localparam logic       OP_SAMPLE = 1'b1;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  localparam logic [6:0] DRIVE_COL0 = 7'h01;

  localparam logic [5:0] MOD_KEY_A = 6'd28;
  localparam logic [5:0] MOD_KEY_B = 6'd36;
  localparam logic [5:0] MOD_KEY_C = 6'd38;
  localparam logic [5:0] MOD_KEY_D = 6'd39;

  typedef struct packed {
    logic       op;
    logic [5:0] row_bits;
  } in_t;

  typedef struct packed {
    logic       key_valid;
    logic [5:0] key_index;
    logic [1:0] status;
    logic       is_mod;
    logic [3:0] set_count;
    logic [6:0] column_drive;
    logic       last;
  } out_t;

  // outcome of one insert attempt, from the merge stage
  typedef struct packed {
    logic [1:0] status;
    logic       wr_en;
  } ins_res_t;

  function automatic logic mod_flag(input logic [5:0] idx);
    mod_flag = (idx == MOD_KEY_A) || (idx == MOD_KEY_B) ||
               (idx == MOD_KEY_C) || (idx == MOD_KEY_D);
  endfunction

  // one-hot drive, columns past the seventh drive nothing
  function automatic logic [6:0] drive_of(input logic [2:0] col);
    drive_of = (col == 3'd7) ? 7'd0 : 7'(7'd1 << col);
  endfunction

endpackage

FILE: sv/kms_lane.sv
// one slot of the key set: holds an entry and compares it with the candidate key
`timescale 1ns / 1ps

module kms_lane #(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic          clk,
  input  logic [CW-1:0] count,
  input  logic [5:0]    key,
  input  logic          wr_en,
  output logic          hit
);

  logic [5:0] entry_r;

  // the slot at the fill count takes the new key
  always_ff @(posedge clk) begin
    if (wr_en && (count == CW'(IDX))) begin
      entry_r <= key;
    end
  end

  assign hit = (CW'(IDX) < count) && (entry_r == key);

endmodule

FILE: sv/kms_merge.sv
// combines the lane compares into the insert status and write enable
`timescale 1ns / 1ps

module kms_merge #(
  parameter int SET_SIZE = 8,
  parameter int CW       = 4
) (
  input  logic [SET_SIZE-1:0] hits,
  input  logic [CW-1:0]       count,
  input  logic                step,
  output kms_pkg::ins_res_t   res
);

  logic full;

  assign full = (count >= CW'(SET_SIZE));

  always_comb begin
    res.wr_en = 1'b0;
    if (full) begin
      res.status = kms_pkg::ST_DROPPED;
    end else if (|hits) begin
      res.status = kms_pkg::ST_PRESENT;
    end else begin
      res.status = kms_pkg::ST_ADDED;
      res.wr_en  = step;
    end
  end

endmodule

FILE: sv/key_matrix_scan_set.sv
// top level of the column-at-a-time key matrix scanner with pressed-key set
`timescale 1ns / 1ps

// Scans a key matrix one column per sample transaction and keeps a set of up to
// SET_SIZE pressed-key indices without duplicates. A clear transaction empties
// the set and restarts at column zero. After a transaction is accepted the block
// emits one result per high row, lowest row first, one per cycle while the output
// is not stalled, or a single keyless result when no row is high or the
// transaction is a clear. The single insert step handles one key a cycle unless
// the output stalls, while SET_SIZE compare lanes check the held keys in
// parallel. The next transaction is taken once the last result is in the output
// register, even if that result has not yet been taken.
module key_matrix_scan_set #(
  parameter int COLS     = 7,
  parameter int ROWS     = 6,
  parameter int SET_SIZE = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  kms_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output kms_pkg::out_t out_data
);

  localparam int CW = $clog2(SET_SIZE + 1);
  localparam int NR = (ROWS < 6) ? ROWS : 6;
  localparam logic [5:0] ROW_MASK = 6'((1 << NR) - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic              state_r;
  logic [CW-1:0]     count_r;
  logic [2:0]        col_r;
  logic [2:0]        col_cur_r;
  logic [6:0]        drv_r;
  logic [5:0]        pend_r;
  logic              out_valid_r;
  kms_pkg::out_t     out_r;

  logic              accept;
  logic              emit;
  logic              has_key;
  logic              step;
  logic              last;
  logic [2:0]        sel;
  logic [5:0]        pend_left;
  logic [6:0]        key_wide;
  logic [5:0]        key;
  logic [3:0]        col_inc;
  logic [2:0]        col_next;
  logic [SET_SIZE-1:0] hits;
  kms_pkg::ins_res_t ins;
  kms_pkg::out_t     res;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign emit      = (state_r == S_BUSY) && (!out_valid_r || out_ready);
  assign has_key   = (pend_r != 6'd0);
  assign step      = emit && has_key;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // lowest pending row first
  always_comb begin
    sel = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = 3'(i);
      end
    end
  end

  assign pend_left = pend_r & ~(6'(6'd1 << sel));
  assign last      = !has_key || (pend_left == 6'd0);
  assign key_wide  = 7'(sel) * 7'(ROWS + 1) + 7'(col_cur_r);
  assign key       = key_wide[5:0];

  assign col_inc  = {1'b0, col_r} + 4'd1;
  assign col_next = (col_inc >= 4'(COLS)) ? 3'd0 : col_inc[2:0];

  for (genvar g = 0; g < SET_SIZE; g++) begin : g_lane
    kms_lane #(
      .IDX (g),
      .CW  (CW)
    ) u_lane (
      .clk   (clk),
      .count (count_r),
      .key   (key),
      .wr_en (ins.wr_en),
      .hit   (hits[g])
    );
  end

  kms_merge #(
    .SET_SIZE (SET_SIZE),
    .CW       (CW)
  ) u_merge (
    .hits  (hits),
    .count (count_r),
    .step  (step),
    .res   (ins)
  );

  always_comb begin
    res.key_valid    = has_key;
    res.key_index    = has_key ? key : 6'd0;
    res.status       = has_key ? ins.status : kms_pkg::ST_ADDED;
    res.is_mod       = has_key && kms_pkg::mod_flag(key);
    res.set_count    = ins.wr_en ? 4'(count_r + CW'(1)) : 4'(count_r);
    res.column_drive = drv_r;
    res.last         = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      col_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= S_BUSY;
        if (in_data.op == kms_pkg::OP_CLEAR) begin
          count_r <= '0;
          col_r   <= 3'd0;
        end else begin
          col_r <= col_next;
        end
      end else if (emit && last) begin
        state_r <= S_IDLE;
      end
      if (ins.wr_en) begin
        count_r <= CW'(count_r + CW'(1));
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_cur_r <= col_r;
      if (in_data.op == kms_pkg::OP_CLEAR) begin
        pend_r <= 6'd0;
        drv_r  <= kms_pkg::DRIVE_COL0;
      end else begin
        pend_r <= in_data.row_bits & ROW_MASK;
        drv_r  <= kms_pkg::drive_of(col_next);
      end
    end else if (step) begin
      pend_r <= pend_left;
    end
    if (emit) begin
      out_r <= res;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SET_SIZE))
    else $error("key count above set size");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < 3'(COLS) || COLS == 8)
    else $error("column past last column");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> (state_r == S_IDLE))
    else $error("scanner busy after final result");

  a_grow_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUSY && !ins.wr_en) |=> (count_r == $past(count_r)))
    else $error("key count changed without an insert");
`endif

endmodule

FILE: verif/key_scan_checker.sv
// checker for the key matrix scanner: predicts scan reports and compares them
`timescale 1ns / 1ps

module key_scan_checker #(
  parameter int COLS     = 7,
  parameter int ROWS     = 6,
  parameter int SET_SIZE = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  kms_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  kms_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);

  logic [5:0]    held_keys [SET_SIZE];
  int            held_n;
  logic [2:0]    scan_col;
  kms_pkg::out_t report_q [$];
  kms_pkg::out_t want;
  int            errors = 0;
  bit            bad;

  task automatic predict_scan(input kms_pkg::in_t item);
    logic [2:0]    col;
    logic [2:0]    nxt;
    logic [5:0]    live;
    logic [5:0]    idx;
    logic [1:0]    st;
    int unsigned   total;
    int unsigned   n;
    kms_pkg::out_t res;
    res = '0;
    if (item.op == kms_pkg::OP_CLEAR) begin
      held_n = 0;
      scan_col = '0;
      res.column_drive = kms_pkg::DRIVE_COL0;
      res.last = 1'b1;
      report_q.push_back(res);
    end else begin
      col = scan_col;
      nxt = (int'(col) + 1 >= COLS) ? 3'd0 : col + 3'd1;
      scan_col = nxt;
      // rows at or above ROWS never form a key
      live = item.row_bits & 6'((64'd1 << ROWS) - 64'd1);
      total = $countones(live);
      n = 0;
      res.set_count = 4'(held_n);
      res.column_drive = (nxt < 3'd7) ? 7'(7'd1 << nxt) : 7'd0;
      if (total == 0) begin
        res.last = 1'b1;
        report_q.push_back(res);
      end
      for (int r = 0; r < 6; r++) begin
        if (live[r]) begin
          idx = 6'(r * (ROWS + 1) + int'(col));
          // a full set drops the key before any duplicate search
          if (held_n >= SET_SIZE) begin
            st = kms_pkg::ST_DROPPED;
          end else begin
            st = kms_pkg::ST_ADDED;
            for (int i = 0; i < held_n; i++) begin
              if (held_keys[i] == idx) st = kms_pkg::ST_PRESENT;
            end
            if (st == kms_pkg::ST_ADDED) begin
              held_keys[held_n] = idx;
              held_n++;
            end
          end
          n++;
          res.key_valid = 1'b1;
          res.key_index = idx;
          res.status = st;
          res.is_mod = idx inside {kms_pkg::MOD_KEY_A, kms_pkg::MOD_KEY_B,
                                   kms_pkg::MOD_KEY_C, kms_pkg::MOD_KEY_D};
          res.set_count = 4'(held_n);
          res.last = (n == total);
          report_q.push_back(res);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      report_q.delete();
      held_n = 0;
      scan_col = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          errors++;
        end else begin
          want = report_q.pop_front();
          bad = 1'b0;
          check_field("key_valid", want.key_valid, out_data.key_valid);
          check_field("key_index", want.key_index, out_data.key_index);
          check_field("status", want.status, out_data.status);
          check_field("is_mod", want.is_mod, out_data.is_mod);
          check_field("set_count", want.set_count, out_data.set_count);
          check_field("column_drive", want.column_drive, out_data.column_drive);
          check_field("last", want.last, out_data.last);
          if (bad) errors++;
        end
      end
      if (in_valid && in_ready) predict_scan(in_data);
    end
    pending <= report_q.size();
    fail_count <= errors;
  end

endmodule

FILE: verif/tb_key_matrix_scan_set.sv
// testbench top for the key matrix scanner: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_key_matrix_scan_set;

  localparam int COLS         = 7;
  localparam int ROWS         = 6;
  localparam int SET_SIZE     = 8;
  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum {RX_FLOW, RX_CHOPPY, RX_HOLD} rx_mode_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  kms_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  kms_pkg::out_t out_data;
  int            fail_count;
  int            pending;
  int            burst_left;
  int            items_sent;
  int            holds_asked;
  int            holds_done;
  int            idle_cycles;

  key_matrix_scan_set #(.COLS(COLS), .ROWS(ROWS), .SET_SIZE(SET_SIZE)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  key_scan_checker #(.COLS(COLS), .ROWS(ROWS), .SET_SIZE(SET_SIZE)) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .fail_count(fail_count),
    .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // offers one transaction, in most cases with a random gap when the current burst runs out
  task automatic send_item(input logic op, input logic [5:0] rows);
    kms_pkg::in_t item;
    item.op = op;
    item.row_bits = rows;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [5:0] pattern [COLS];
    logic [5:0] rows;
    int         first_random;
    bit         paused;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    burst_left = 0;
    items_sent = 0;
    holds_asked = 0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(kms_pkg::OP_SAMPLE, 6'h00);  // empty column straight out of reset
    send_item(kms_pkg::OP_CLEAR, 6'h3F);   // row lines ignored on clear
    send_item(kms_pkg::OP_SAMPLE, 6'h10);  // column 0, row 4: modifier
    send_item(kms_pkg::OP_SAMPLE, 6'h20);
    send_item(kms_pkg::OP_SAMPLE, 6'h00);
    send_item(kms_pkg::OP_SAMPLE, 6'h20);
    send_item(kms_pkg::OP_SAMPLE, 6'h20);
    send_item(kms_pkg::OP_SAMPLE, 6'h01);
    send_item(kms_pkg::OP_SAMPLE, 6'h00);  // last column, scan wraps
    send_item(kms_pkg::OP_SAMPLE, 6'h10);  // same key again: already held
    send_item(kms_pkg::OP_SAMPLE, 6'h3F);  // set fills, a held key gets dropped too
    send_item(kms_pkg::OP_SAMPLE, 6'h3F);
    send_item(kms_pkg::OP_CLEAR, 6'h00);
    for (int c = 0; c < COLS; c++) send_item(kms_pkg::OP_SAMPLE, 6'h3F);
    send_item(kms_pkg::OP_CLEAR, 6'h2A);
    send_item(kms_pkg::OP_SAMPLE, 6'h2A);
    send_item(kms_pkg::OP_SAMPLE, 6'h15);
    wait_drained();

    // long receiver hold while the sender keeps pushing
    holds_asked++;
    first_random = items_sent;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      if (!paused && items_sent - first_random >= RANDOM_ITEMS / 2) begin
        wait_drained();
        holds_asked++;
        paused = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        // noise: samples out of step with the scan and stray clears
        repeat ($urandom_range(1, 6)) begin
          send_item(($urandom_range(0, 3) != 0) ? kms_pkg::OP_SAMPLE : kms_pkg::OP_CLEAR,
                    6'($urandom_range(0, 63)));
        end
      end else begin
        send_item(kms_pkg::OP_CLEAR, 6'($urandom_range(0, 63)));
        for (int c = 0; c < COLS; c++) begin
          pattern[c] = '0;
          if ($urandom_range(0, 7) == 0) begin
            pattern[c] = 6'($urandom_range(0, 63));
          end else begin
            repeat ($urandom_range(0, 2)) pattern[c][$urandom_range(0, 5)] = 1'b1;
          end
        end
        // rescanning the same held keys gives duplicates
        repeat ($urandom_range(1, 3)) begin
          for (int c = 0; c < COLS; c++) begin
            rows = pattern[c];
            if ($urandom_range(0, 11) == 0) rows[$urandom_range(0, 5)] ^= 1'b1;
            send_item(kms_pkg::OP_SAMPLE, rows);
          end
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side: segments of free flow, random stalls and long holds
  initial begin
    rx_mode_t mode;
    int       seg_len;
    int       ready_pct;
    out_ready = 1'b0;
    holds_done = 0;
    @(posedge rst_n);
    forever begin
      ready_pct = $urandom_range(20, 80);
      if (holds_done != holds_asked) begin
        holds_done++;
        mode = RX_HOLD;
        seg_len = 120;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            mode = RX_HOLD;
            seg_len = $urandom_range(30, 80);
          end
          1, 2, 3: begin
            mode = RX_FLOW;
            seg_len = $urandom_range(10, 60);
          end
          default: begin
            mode = RX_CHOPPY;
            seg_len = $urandom_range(10, 60);
          end
        endcase
      end
      repeat (seg_len) begin
        @(negedge clk);
        case (mode)
          RX_FLOW: out_ready <= 1'b1;
          RX_HOLD: out_ready <= 1'b0;
          default: out_ready <= ($urandom_range(1, 100) <= ready_pct);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
